/* rtl/cbq_pkg.sv */
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types and codes of the stereo biquad cascade: action codes,
// coefficient slots, internal word widths and the structs between modules.
// ----------------------------------------------------------------------------
package cbq_pkg;

  // internal value format Q8.24 and accumulator widths
  localparam int INT_W  = 32;
  localparam int TERM_W = 36;
  localparam int ACC_W  = 40;

  // action carried on the input tuser
  localparam logic [1:0] ACT_FILTER = 2'd0;
  localparam logic [1:0] ACT_COEF   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // coefficient slot of a section, also the product step within a section
  localparam logic [2:0] K_B0     = 3'd0;
  localparam logic [2:0] K_B1     = 3'd1;
  localparam logic [2:0] K_B2     = 3'd2;
  localparam logic [2:0] K_A1     = 3'd3;
  localparam logic [2:0] K_A2     = 3'd4;
  localparam logic [2:0] NUM_COEF = 3'd5;

  // one product step issued by the sequencer
  typedef struct packed {
    logic       vld;
    logic       ch;
    logic [2:0] k;
  } issue_t;

  // history write-back of one section and channel
  typedef struct packed {
    logic             vld;
    logic [INT_W-1:0] x;
    logic [INT_W-1:0] h0;
    logic [INT_W-1:0] y;
    logic [INT_W-1:0] h2;
  } wb_req_t;

endpackage

/* rtl/cbq_coef_store.sv */
// ----------------------------------------------------------------------------
// cbq_coef_store
// Coefficient memory, five words per section, one write and one registered
// read a cycle. Entries never written read as pass-through (b0 one).
// ----------------------------------------------------------------------------
module cbq_coef_store #(
  parameter int SECTIONS  = 16,
  parameter int COEF_BITS = 32,
  localparam int CA_W     = $clog2(SECTIONS * 5)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CA_W-1:0]      wr_addr,
  input  logic [COEF_BITS-1:0] wr_data,
  input  logic [CA_W-1:0]      rd_addr,
  input  logic                 rd_b0,
  output logic [COEF_BITS-1:0] rd_data
);
  import cbq_pkg::*;

  localparam int DEPTH = SECTIONS * int'(NUM_COEF);
  localparam logic [COEF_BITS-1:0] ONE = COEF_BITS'(1) << (COEF_BITS - 4);

  logic [COEF_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     cv_r;
  logic [DEPTH-1:0]     cv_nxt;
  logic [COEF_BITS-1:0] rdata_r;
  logic                 rvld_r;
  logic                 rb0_r;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
    rvld_r  <= cv_r[rd_addr];
    rb0_r   <= rd_b0;
  end

  // written flags per entry
  always_comb begin
    cv_nxt = cv_r;
    if (wr_en) begin
      cv_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= '0;
    end else begin
      cv_r <= cv_nxt;
    end
  end

  // unwritten entries give the reset coefficient
  assign rd_data = rvld_r ? rdata_r : (rb0_r ? ONE : '0);

endmodule

/* rtl/cbq_hist_store.sv */
// ----------------------------------------------------------------------------
// cbq_hist_store
// History memory, x1 x2 y1 y2 per section and channel, with a registered
// read port and a four-word write-back buffer. Row flags make clear instant.
// ----------------------------------------------------------------------------
module cbq_hist_store #(
  parameter int SECTIONS = 16,
  localparam int SEC_W   = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cbq_pkg::issue_t                  iss,
  input  logic [SEC_W-1:0]                 iss_sec,
  input  logic                             clear,
  input  cbq_pkg::wb_req_t                 wb,
  input  logic [SEC_W:0]                   wb_row,
  output logic [cbq_pkg::INT_W-1:0]        rd_data,
  output logic                             busy
);
  import cbq_pkg::*;

  localparam int ROWS  = 2 * (1 << SEC_W);
  localparam int DEPTH = ROWS * 4;

  logic [INT_W-1:0] mem [DEPTH];
  logic [ROWS-1:0]  hv_r;
  logic [ROWS-1:0]  hv_nxt;
  logic [INT_W-1:0] rdata_r;
  logic             rvld_r;
  logic [1:0]       rd_word;
  logic [SEC_W:0]   rd_row;

  logic [INT_W-1:0] wb_x_r;
  logic [INT_W-1:0] wb_h0_r;
  logic [INT_W-1:0] wb_y_r;
  logic [INT_W-1:0] wb_h2_r;
  logic [SEC_W:0]   wb_row_r;
  logic [1:0]       wb_cnt_r;
  logic [1:0]       wb_cnt_nxt;
  logic             busy_r;
  logic             busy_nxt;
  logic [INT_W-1:0] wdata;

  // step k reads history word k-1
  assign rd_word = 2'(iss.k - K_B1);
  assign rd_row  = {iss_sec, iss.ch};

  // write word order: x1 gets x, x2 old x1, y1 gets y, y2 old y1
  always_comb begin
    case (wb_cnt_r)
      2'd0:    wdata = wb_x_r;
      2'd1:    wdata = wb_h0_r;
      2'd2:    wdata = wb_y_r;
      default: wdata = wb_h2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[{wb_row_r, wb_cnt_r}] <= wdata;
    end
    rdata_r <= mem[{rd_row, rd_word}];
    rvld_r  <= hv_r[rd_row];
  end

  // write-back buffer load
  always_ff @(posedge clk) begin
    if (wb.vld) begin
      wb_x_r   <= wb.x;
      wb_h0_r  <= wb.h0;
      wb_y_r   <= wb.y;
      wb_h2_r  <= wb.h2;
      wb_row_r <= wb_row;
    end
  end

  // write-back sequencing and row flags
  always_comb begin
    hv_nxt     = hv_r;
    wb_cnt_nxt = wb_cnt_r;
    busy_nxt   = busy_r;
    if (wb.vld) begin
      busy_nxt   = 1'b1;
      wb_cnt_nxt = 2'd0;
    end else if (busy_r) begin
      wb_cnt_nxt = wb_cnt_r + 2'd1;
      if (wb_cnt_r == 2'd3) begin
        busy_nxt           = 1'b0;
        hv_nxt[wb_row_r]   = 1'b1;
      end
    end
    if (clear) begin
      hv_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r     <= '0;
      busy_r   <= 1'b0;
      wb_cnt_r <= 2'd0;
    end else begin
      hv_r     <= hv_nxt;
      busy_r   <= busy_nxt;
      wb_cnt_r <= wb_cnt_nxt;
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;
  assign busy    = busy_r;

endmodule

/* rtl/cbq_mac.sv */
// ----------------------------------------------------------------------------
// cbq_mac
// Shared multiply-accumulate pipeline: operand select, split multiply,
// floor shift, accumulate, saturate. Holds the running value per channel.
// ----------------------------------------------------------------------------
module cbq_mac #(
  parameter int SECTIONS  = 16,
  parameter int COEF_BITS = 32,
  localparam int SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cbq_pkg::issue_t            iss,
  input  logic [SEC_W-1:0]           iss_sec,
  input  logic                       load,
  input  logic [cbq_pkg::INT_W-1:0]  load_l,
  input  logic [cbq_pkg::INT_W-1:0]  load_r,
  input  logic [COEF_BITS-1:0]       coef_rd,
  input  logic [cbq_pkg::INT_W-1:0]  hist_rd,
  output logic [cbq_pkg::INT_W-1:0]  x_left,
  output logic [cbq_pkg::INT_W-1:0]  x_right,
  output cbq_pkg::wb_req_t           wb,
  output logic [SEC_W:0]             wb_row,
  output logic                       y_clip,
  output logic                       busy
);
  import cbq_pkg::*;

  localparam int CFRAC = COEF_BITS - 4;
  localparam int HI_W  = COEF_BITS - 16;
  localparam int PW    = INT_W + COEF_BITS;

  // data stage control
  logic             d_vld_r;
  logic             d_ch_r;
  logic [2:0]       d_k_r;
  logic [SEC_W-1:0] d_sec_r;
  // multiply stage control
  logic             m_vld_r;
  logic [2:0]       m_k_r;
  logic             m_ch_r;
  logic [SEC_W-1:0] m_sec_r;
  // accumulate stage control
  logic             a_vld_r;
  logic [2:0]       a_k_r;
  logic             a_ch_r;
  logic [SEC_W-1:0] a_sec_r;
  // result stage control
  logic             y_vld_r;
  logic             y_ch_r;
  logic [SEC_W-1:0] y_sec_r;

  logic signed [INT_W-1:0]      xl_r;
  logic signed [INT_W-1:0]      xr_r;
  logic signed [INT_W-1:0]      op;
  logic signed [16:0]           clo_s;
  logic signed [HI_W-1:0]       chi_s;
  logic signed [INT_W+16:0]     plo_nxt;
  logic signed [INT_W+HI_W-1:0] phi_nxt;
  logic signed [INT_W+16:0]     plo_r;
  logic signed [INT_W+HI_W-1:0] phi_r;
  logic signed [PW-1:0]         full;
  logic signed [TERM_W-1:0]     term_nxt;
  logic signed [TERM_W-1:0]     term_r;
  logic signed [ACC_W-1:0]      acc_base;
  logic signed [ACC_W-1:0]      term_ext;
  logic signed [ACC_W-1:0]      acc_nxt;
  logic signed [ACC_W-1:0]      acc_r;
  logic                         ovf;
  logic signed [INT_W-1:0]      y;

  logic [INT_W-1:0] cap_x_r;
  logic [INT_W-1:0] cap_h0_r;
  logic [INT_W-1:0] cap_h2_r;
  logic [INT_W-1:0] pend_x_r;
  logic [INT_W-1:0] pend_h0_r;
  logic [INT_W-1:0] pend_h2_r;

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      m_vld_r <= 1'b0;
      a_vld_r <= 1'b0;
      y_vld_r <= 1'b0;
    end else begin
      d_vld_r <= iss.vld;
      m_vld_r <= d_vld_r;
      a_vld_r <= m_vld_r;
      y_vld_r <= a_vld_r && (a_k_r == K_A2);
    end
  end

  // stage tags
  always_ff @(posedge clk) begin
    d_ch_r  <= iss.ch;
    d_k_r   <= iss.k;
    d_sec_r <= iss_sec;
    m_ch_r  <= d_ch_r;
    m_k_r   <= d_k_r;
    m_sec_r <= d_sec_r;
    a_ch_r  <= m_ch_r;
    a_k_r   <= m_k_r;
    a_sec_r <= m_sec_r;
    y_ch_r  <= a_ch_r;
    y_sec_r <= a_sec_r;
  end

  // operand: section input on b0, stored history otherwise
  assign op    = (d_k_r == K_B0) ? (d_ch_r ? xr_r : xl_r) : $signed(hist_rd);
  assign clo_s = $signed({1'b0, coef_rd[15:0]});
  assign chi_s = $signed(coef_rd[COEF_BITS-1:16]);

  // split multiply, low half unsigned, high half signed
  assign plo_nxt = op * clo_s;
  assign phi_nxt = op * chi_s;

  always_ff @(posedge clk) begin
    plo_r <= plo_nxt;
    phi_r <= phi_nxt;
  end

  // old history words kept for the write-back
  always_ff @(posedge clk) begin
    if (d_vld_r) begin
      case (d_k_r)
        K_B0:    cap_x_r  <= op;
        K_B1:    cap_h0_r <= op;
        K_A1:    cap_h2_r <= op;
        K_A2: begin
          pend_x_r  <= cap_x_r;
          pend_h0_r <= cap_h0_r;
          pend_h2_r <= cap_h2_r;
        end
        default: ;
      endcase
    end
  end

  // recombine and floor shift to the internal format
  assign full     = (PW'(phi_r) <<< 16) + PW'(plo_r);
  assign term_nxt = TERM_W'(full >>> CFRAC);

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
  end

  // accumulate, feedback terms subtract
  assign acc_base = (a_k_r == K_B0) ? '0 : acc_r;
  assign term_ext = ACC_W'(term_r);
  assign acc_nxt  = ((a_k_r == K_A1) || (a_k_r == K_A2)) ? acc_base - term_ext
                                                          : acc_base + term_ext;

  always_ff @(posedge clk) begin
    if (a_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  // saturate section sum to 32 bits
  assign ovf = !((&acc_r[ACC_W-1:INT_W-1]) || !(|acc_r[ACC_W-1:INT_W-1]));
  assign y   = ovf ? {acc_r[ACC_W-1], {(INT_W-1){~acc_r[ACC_W-1]}}} : acc_r[INT_W-1:0];

  // running value per channel
  always_ff @(posedge clk) begin
    if (load) begin
      xl_r <= $signed(load_l);
      xr_r <= $signed(load_r);
    end else if (y_vld_r) begin
      if (y_ch_r) begin
        xr_r <= y;
      end else begin
        xl_r <= y;
      end
    end
  end

  assign wb.vld  = y_vld_r;
  assign wb.x    = pend_x_r;
  assign wb.h0   = pend_h0_r;
  assign wb.y    = y;
  assign wb.h2   = pend_h2_r;
  assign wb_row  = {y_sec_r, y_ch_r};
  assign y_clip  = y_vld_r && ovf;
  assign busy    = d_vld_r || m_vld_r || a_vld_r || y_vld_r;
  assign x_left  = xl_r;
  assign x_right = xr_r;

endmodule

/* rtl/cascaded_biquad_parametric_eq.sv */
// ----------------------------------------------------------------------------
// cascaded_biquad_parametric_eq
// Stereo cascade of direct-form-I biquad sections with coefficient memory,
// history memory and one shared multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  in_*    | in  | tuser: action; tdata: samples, band, coef slot, coef value;
//          |     | tlast: frame_last
//  out_*   | out | tdata: out_left, out_right; tlast: frame_last_out;
//          |     | tuser: clipped
//
//  Filter word: the product steps of every section, left and right interleaved
//  per section, then a drain (four stages, a four-word history write, one
//  check) and one output load; the next word is taken once the result is
//  loaded into the output register. Coefficient and clear words are handled
//  on accept without leaving idle. Reset needs no clearing pass: per-entry
//  and per-row flags give pass-through coefficients and zero history. A result
//  held in the output register stalls only the finish of the following frame.
// ----------------------------------------------------------------------------
module cascaded_biquad_parametric_eq #(
  parameter int SECTIONS    = 16,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 32,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7 + COEF_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // sample_left, sample_right, band_index, coef_select, coef_value
  input  logic [IN_W-1:0]  in_tdata,
  // action
  input  logic [1:0]       in_tuser,
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  // out_left, out_right
  output logic [OUT_W-1:0] out_tdata,
  // clipped
  output logic             out_tuser,
  output logic             out_tlast
);
  import cbq_pkg::*;

  localparam int SEC_W   = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int CA_W    = $clog2(SECTIONS * 5);
  localparam int AX      = SEC_W + CA_W + 4;
  localparam int BAND_LO = 2 * SAMPLE_BITS;
  localparam int SEL_LO  = BAND_LO + 4;
  localparam int COEF_LO = SEL_LO + 3;
  localparam int OW      = INT_W + ((SAMPLE_BITS > 25) ? SAMPLE_BITS - 25 : 0);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state_r;
  logic [1:0]       state_nxt;
  logic [SEC_W-1:0] sec_r;
  logic [SEC_W-1:0] sec_nxt;
  logic             ch_r;
  logic             ch_nxt;
  logic [2:0]       k_r;
  logic [2:0]       k_nxt;

  logic                          in_acc;
  logic                          start;
  logic signed [SAMPLE_BITS-1:0] smp_l;
  logic signed [SAMPLE_BITS-1:0] smp_r;
  logic [3:0]                    band;
  logic [2:0]                    sel;
  logic [COEF_BITS-1:0]          coef_in;
  logic [INT_W-1:0]              in_l_int;
  logic [INT_W-1:0]              in_r_int;

  logic [AX-1:0]        rd_full;
  logic [AX-1:0]        wr_full;
  logic [CA_W-1:0]      coef_rd_addr;
  logic [CA_W-1:0]      coef_wr_addr;
  logic                 coef_wr;
  logic [COEF_BITS-1:0] coef_rd;
  logic                 hist_clear;
  logic [INT_W-1:0]     hist_rd;
  logic                 hist_busy;

  issue_t           iss;
  wb_req_t          wb;
  logic [SEC_W:0]   wb_row;
  logic             mac_clip;
  logic             mac_busy;
  logic [INT_W-1:0] x_left;
  logic [INT_W-1:0] x_right;

  logic [OW-1:0]          wide_l;
  logic [OW-1:0]          wide_r;
  logic [SAMPLE_BITS:0]   fin_l;
  logic [SAMPLE_BITS:0]   fin_r;
  logic                   out_free;
  logic                   out_load;
  logic                   clip_r;
  logic                   last_r;
  logic                   out_tvalid_r;
  logic [SAMPLE_BITS-1:0] out_l_r;
  logic [SAMPLE_BITS-1:0] out_r_r;
  logic                   out_clip_r;
  logic                   out_last_r;

  // saturate to the sample width, top bit flags the clip
  function automatic logic [SAMPLE_BITS:0] sat_out(input logic [OW-1:0] v);
    logic ovf;
    ovf = !((&v[OW-1:SAMPLE_BITS-1]) || !(|v[OW-1:SAMPLE_BITS-1]));
    if (ovf) begin
      sat_out = {1'b1, v[OW-1], {(SAMPLE_BITS-1){~v[OW-1]}}};
    end else begin
      sat_out = {1'b0, v[SAMPLE_BITS-1:0]};
    end
  endfunction

  // input word fields
  assign in_acc  = in_tvalid && in_tready;
  assign smp_l   = $signed(in_tdata[SAMPLE_BITS-1:0]);
  assign smp_r   = $signed(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
  assign band    = in_tdata[BAND_LO+3:BAND_LO];
  assign sel     = in_tdata[SEL_LO+2:SEL_LO];
  assign coef_in = in_tdata[COEF_LO+COEF_BITS-1:COEF_LO];
  assign start   = in_acc && (in_tuser == ACT_FILTER);

  // sample to internal format and back
  generate
    if (SAMPLE_BITS <= 25) begin : g_up
      localparam int UP = 25 - SAMPLE_BITS;
      assign in_l_int = INT_W'(smp_l) <<< UP;
      assign in_r_int = INT_W'(smp_r) <<< UP;
      assign wide_l   = OW'($signed(x_left) >>> UP);
      assign wide_r   = OW'($signed(x_right) >>> UP);
    end else begin : g_dn
      localparam int DN = SAMPLE_BITS - 25;
      assign in_l_int = INT_W'(smp_l >>> DN);
      assign in_r_int = INT_W'(smp_r >>> DN);
      assign wide_l   = OW'($signed(x_left)) <<< DN;
      assign wide_r   = OW'($signed(x_right)) <<< DN;
    end
  endgenerate

  assign fin_l = sat_out(wide_l);
  assign fin_r = sat_out(wide_r);

  // coefficient addresses, section times five plus slot
  assign rd_full      = AX'({sec_r, 2'b00}) + AX'(sec_r) + AX'(k_r);
  assign coef_rd_addr = rd_full[CA_W-1:0];
  assign wr_full      = AX'({band, 2'b00}) + AX'(band) + AX'(sel);
  assign coef_wr_addr = wr_full[CA_W-1:0];
  assign coef_wr      = in_acc && (in_tuser == ACT_COEF) &&
                        (32'(band) < SECTIONS) && (sel < NUM_COEF);
  assign hist_clear   = in_acc && (in_tuser == ACT_CLEAR);

  // product step issue
  assign iss.vld = (state_r == ST_RUN);
  assign iss.ch  = ch_r;
  assign iss.k   = k_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    sec_nxt   = sec_r;
    ch_nxt    = ch_r;
    k_nxt     = k_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          sec_nxt   = '0;
          ch_nxt    = 1'b0;
          k_nxt     = K_B0;
        end
      end
      ST_RUN: begin
        if (k_r == K_A2) begin
          k_nxt = K_B0;
          if (ch_r) begin
            ch_nxt = 1'b0;
            if (sec_r == SEC_W'(SECTIONS - 1)) begin
              state_nxt = ST_DRAIN;
            end else begin
              sec_nxt = sec_r + 1'b1;
            end
          end else begin
            ch_nxt = 1'b1;
          end
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy && !hist_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sec_r   <= '0;
      ch_r    <= 1'b0;
      k_r     <= K_B0;
    end else begin
      state_r <= state_nxt;
      sec_r   <= sec_nxt;
      ch_r    <= ch_nxt;
      k_r     <= k_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  // frame flags
  always_ff @(posedge clk) begin
    if (start) begin
      last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r <= 1'b0;
    end else if (start) begin
      clip_r <= 1'b0;
    end else if (mac_clip) begin
      clip_r <= 1'b1;
    end
  end

  // output register
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_l_r    <= fin_l[SAMPLE_BITS-1:0];
      out_r_r    <= fin_r[SAMPLE_BITS-1:0];
      out_clip_r <= clip_r || fin_l[SAMPLE_BITS] || fin_r[SAMPLE_BITS];
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({out_r_r, out_l_r});
  assign out_tuser  = out_clip_r;
  assign out_tlast  = out_last_r;

  cbq_coef_store #(
    .SECTIONS  (SECTIONS),
    .COEF_BITS (COEF_BITS)
  ) u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (coef_wr),
    .wr_addr (coef_wr_addr),
    .wr_data (coef_in),
    .rd_addr (coef_rd_addr),
    .rd_b0   (k_r == K_B0),
    .rd_data (coef_rd)
  );

  cbq_hist_store #(
    .SECTIONS (SECTIONS)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .iss     (iss),
    .iss_sec (sec_r),
    .clear   (hist_clear),
    .wb      (wb),
    .wb_row  (wb_row),
    .rd_data (hist_rd),
    .busy    (hist_busy)
  );

  cbq_mac #(
    .SECTIONS  (SECTIONS),
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .iss     (iss),
    .iss_sec (sec_r),
    .load    (start),
    .load_l  (in_l_int),
    .load_r  (in_r_int),
    .coef_rd (coef_rd),
    .hist_rd (hist_rd),
    .x_left  (x_left),
    .x_right (x_right),
    .wb      (wb),
    .wb_row  (wb_row),
    .y_clip  (mac_clip),
    .busy    (mac_busy)
  );

endmodule
